// ===== design/assert_macros.svh =====
// Assertion macros shared by the address region table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ART_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication outside reset.
`define ART_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define ART_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ART_ASSERT(lbl, clk, rst_n, prop, msg)
`define ART_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ART_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/art_pkg.sv =====
// Types, constants and codes of the address region table.
`timescale 1ns / 1ps
package art_pkg;

  localparam int REGIONS = 16;
  localparam int IDX_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int ADDR_W  = 64;
  localparam int PERM_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

  // Item modes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERLAP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [PERM_W-1:0] perm;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [PERM_W-1:0] found_perm;
    logic [ADDR_W-1:0] found_base;
    logic [ADDR_W-1:0] covered_bytes;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic             capture;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/art_ctrl.sv =====
// Sequencer for the region scan: capture, entry walk, drain and commit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module art_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  art_pkg::dp_status_t status,
  output art_pkg::ctrl_cmd_t  cmd
);

  art_pkg::ctrl_state_t state_r, state_nxt;
  logic [art_pkg::IDX_W-1:0] cnt_r, cnt_nxt;

  // State and scan counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= art_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      art_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = art_pkg::ST_SCAN;
      end
      art_pkg::ST_SCAN: begin
        if (cnt_r == art_pkg::LAST_IDX) state_nxt = art_pkg::ST_DRAIN;
      end
      art_pkg::ST_DRAIN: begin
        state_nxt = art_pkg::ST_COMMIT;
      end
      art_pkg::ST_COMMIT: begin
        if (status.out_free) state_nxt = art_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = art_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and counter update
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_idx  = cnt_r;
    cmd.commit  = 1'b0;
    cnt_nxt     = cnt_r;
    case (state_r)
      art_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        cnt_nxt     = '0;
      end
      art_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r != art_pkg::LAST_IDX) cnt_nxt = cnt_r + 1'b1;
      end
      art_pkg::ST_DRAIN: begin
        cmd.rd_en = 1'b0;
      end
      art_pkg::ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  `ART_ASSERT_IMP(a_cnt_bound, clk, rst_n, state_r == art_pkg::ST_SCAN, cnt_r <= art_pkg::LAST_IDX, "scan index beyond table")
  `ART_ASSERT_NXT(a_commit_idle, clk, rst_n, cmd.commit, state_r == art_pkg::ST_IDLE && !in_stall, "commit did not return to idle")
  `ART_ASSERT_NXT(a_drain_commit, clk, rst_n, state_r == art_pkg::ST_DRAIN, state_r == art_pkg::ST_COMMIT, "drain not followed by commit")

endmodule

// ===== design/art_dp.sv =====
// Region storage, per-entry compare, result accumulation and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module art_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  art_pkg::in_item_t   in_data,
  input  art_pkg::ctrl_cmd_t  cmd,
  output art_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output art_pkg::out_item_t  out_data
);

  // Region memories; contents are only trusted where the used bit is set
  logic [art_pkg::ADDR_W-1:0] base_mem [art_pkg::REGIONS];
  logic [art_pkg::ADDR_W-1:0] len_mem  [art_pkg::REGIONS];
  logic [art_pkg::PERM_W-1:0] perm_mem [art_pkg::REGIONS];
  logic [art_pkg::REGIONS-1:0] used_r;

  art_pkg::in_item_t          item_r;
  logic                       rd_vld_r;
  logic [art_pkg::IDX_W-1:0]  rd_idx_r;
  logic [art_pkg::ADDR_W-1:0] rd_base_r;
  logic [art_pkg::ADDR_W-1:0] rd_len_r;
  logic [art_pkg::PERM_W-1:0] rd_perm_r;

  logic                       clash_r;
  logic                       hit_r;
  logic [art_pkg::PERM_W-1:0] fperm_r;
  logic [art_pkg::ADDR_W-1:0] fbase_r;
  logic                       free_found_r;
  logic [art_pkg::IDX_W-1:0]  free_idx_r;
  logic [art_pkg::ADDR_W-1:0] total_r;

  logic                       out_valid_r;
  art_pkg::out_item_t         out_data_r;

  logic                       ent_used;
  logic [art_pkg::ADDR_W-1:0] diff_ba;
  logic [art_pkg::ADDR_W-1:0] diff_ab;
  logic                       ent_conflict;
  logic                       ent_holds;
  logic                       add_ok;
  logic [art_pkg::STAT_W-1:0] res_status;
  logic [art_pkg::ADDR_W-1:0] total_new;

  // Compare the entry read last cycle against the held item
  always_comb begin
    ent_used     = used_r[rd_idx_r];
    diff_ba      = rd_base_r - item_r.address;
    diff_ab      = item_r.address - rd_base_r;
    ent_conflict = (rd_base_r == item_r.address) ||
                   ((rd_base_r > item_r.address) && (diff_ba < item_r.length)) ||
                   ((item_r.address > rd_base_r) && (diff_ab < rd_len_r));
    ent_holds    = (item_r.address >= rd_base_r) && (diff_ab < rd_len_r);
  end

  // Result of the finished scan
  always_comb begin
    add_ok     = (item_r.mode == art_pkg::MODE_ADD) && !clash_r && free_found_r;
    total_new  = total_r + item_r.length;
    res_status = art_pkg::STAT_OK;
    if (item_r.mode == art_pkg::MODE_ADD) begin
      if (clash_r) res_status = art_pkg::STAT_OVERLAP;
      else if (!free_found_r) res_status = art_pkg::STAT_FULL;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // Memory read port and commit write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_base_r <= base_mem[cmd.rd_idx];
      rd_len_r  <= len_mem[cmd.rd_idx];
      rd_perm_r <= perm_mem[cmd.rd_idx];
    end
    if (cmd.commit && add_ok) begin
      base_mem[free_idx_r] <= item_r.address;
      len_mem[free_idx_r]  <= item_r.length;
      perm_mem[free_idx_r] <= item_r.perm;
    end
  end

  // Held item and scan accumulators
  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.rd_idx;
    if (cmd.capture) begin
      item_r       <= in_data;
      clash_r      <= 1'b0;
      hit_r        <= 1'b0;
      fperm_r      <= '0;
      fbase_r      <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else if (rd_vld_r) begin
      if (ent_used) begin
        if (ent_conflict) clash_r <= 1'b1;
        // first hit in slot order wins
        if (item_r.mode == art_pkg::MODE_LOOKUP && ent_holds && !hit_r) begin
          hit_r   <= 1'b1;
          fperm_r <= rd_perm_r;
          fbase_r <= rd_base_r;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  // Control state: read valid, used bits, running total, output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.commit && add_ok) begin
        used_r[free_idx_r] <= 1'b1;
        total_r            <= total_new;
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded at commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.status        <= res_status;
      out_data_r.hit           <= hit_r;
      out_data_r.found_perm    <= fperm_r;
      out_data_r.found_base    <= fbase_r;
      out_data_r.covered_bytes <= add_ok ? total_new : total_r;
    end
  end

  `ART_ASSERT_IMP(a_free_slot, clk, rst_n, cmd.commit && add_ok, !used_r[free_idx_r], "add into a used slot")
  `ART_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r, "stalled beat dropped")
  `ART_ASSERT(a_hit_lookup, clk, rst_n, !(out_valid_r && out_data_r.hit && out_data_r.status != art_pkg::STAT_OK), "hit with non-ok status")

endmodule

// ===== design/address_region_table.sv =====
// Top level of the address region table.
`timescale 1ns / 1ps
// Address region table: stores up to art_pkg::REGIONS non-overlapping regions
// (base, length, flags). Mode 0 adds a region into the lowest free slot unless
// a stored region conflicts with it (status 1) or the table is full (status 2);
// mode 1 looks up an address and returns hit, flags and base of the first
// matching slot. Every result carries the running sum of stored lengths,
// modulo 2^64. One item is in work at a time. After the accepting edge the
// stored entries are read from the region memory one slot per cycle over its
// single read port, followed by a drain state to compare the last entry and a
// commit state that loads the result beat into the output register. The commit
// state stretches for as long as the output register still holds a stalled
// beat. The input is taken in the idle state after a commit, so a new item is
// not accepted before the last one is committed. A finished result waits in the
// output register while the next item is accepted and scanned. After reset the
// table is empty at once; there is no clearing pass.
module address_region_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  art_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output art_pkg::out_item_t out_data
);

  art_pkg::ctrl_cmd_t  cmd;
  art_pkg::dp_status_t status;

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  art_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
